>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Needs signals named clock and reset in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DSP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also checks across reset.
`define DSP_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/dsp_pkg.sv
// Shared types and constants for the DAC sample playback core.
// No dependencies; used by the core and its checker.
package dsp_pkg;

   // Store depth must be a power of two; indexes wrap by truncation.
   localparam int STORE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int BSZ_W       = 11;
   localparam int CMP_W       = (IDX_W + 2 > BSZ_W) ? IDX_W + 2 : BSZ_W;

   localparam logic [15:0]      MUTE_WORD       = 16'h0300;
   localparam logic [BSZ_W-1:0] BUFFER_SIZE_RST = 11'd1024;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_SET   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OUT_MUTE   = 2'd0,
      OUT_MONO   = 2'd1,
      OUT_STEREO = 2'd2
   } outmode_type;

   localparam logic CSR_BUFFER_SIZE = 1'b0;
   localparam logic CSR_RING_MODE   = 1'b1;

endpackage

>>> hdl/dac_sample_playback_core.sv
// Sample playback core: sample store, read position and output register.
// Depends on dsp_pkg.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: index, value, output mode; tuser: kind
//  rsp     | out | rsp_tvalid/tready    | tdata: left, right; tuser: powered_down
//  csr     | in  | csr_wen (no wait)    | csr_addr, csr_wdata
//
// One word accepted per cycle while req_tready is high. A tick's result
// passes through the synchronous store read and then the output register.
// Writes and mode sets give no result. Reset clears position, output mode,
// ring mode and pipeline valids and sets buffer size to 1024; the store
// keeps its contents. A stall on rsp backs up through the read stage.
module dac_sample_playback_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [9:0] sample_index, [25:10] sample_value,
                                    // [27:26] output_mode, [31:28] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] left_word, [31:16] right_word
   output logic        rsp_tuser,   // [0] powered_down
   input  logic        csr_wen,
   input  logic        csr_addr,
   input  logic [10:0] csr_wdata
);

   localparam int IW = dsp_pkg::IDX_W;
   localparam int CW = dsp_pkg::CMP_W;

   logic [15:0] sample_store_ff [dsp_pkg::STORE_DEPTH];

   logic [dsp_pkg::BSZ_W-1:0] bsize_ff;
   logic                      ring_ff;
   logic [IW-1:0]             pos_ff, pos_in;
   dsp_pkg::outmode_type      omode_ff, omode_in;

   logic        s1_valid_ff, s1_mute_ff, s1_mono_ff;
   logic [15:0] rd_l_ff, rd_r_ff;
   logic        out_valid_ff;
   logic [31:0] out_data_ff;
   logic        out_pd_ff;

   logic        accept, tick, s1_move;
   logic [9:0]  f_index;
   logic [15:0] f_value;
   logic [1:0]  f_omode;
   logic [IW-1:0] wr_addr, pos_p1;
   logic [CW-1:0] next_pos;
   logic [15:0]   left_w, right_w;

   assign f_index = req_tdata[9:0];
   assign f_value = req_tdata[25:10];
   assign f_omode = req_tdata[27:26];

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;
   assign tick       = accept && (req_tuser == dsp_pkg::KIND_TICK);

   assign wr_addr = IW'(f_index);
   assign pos_p1  = pos_ff + IW'(1);

   // Advance position on ticks, fall back to mute when a linear buffer runs out, and apply mode sets.
   always_comb begin
      pos_in   = pos_ff;
      omode_in = omode_ff;
      next_pos = CW'(pos_ff) + ((omode_ff == dsp_pkg::OUT_STEREO) ? CW'(2) : CW'(1));
      if (accept) begin
         unique case (req_tuser)
            dsp_pkg::KIND_TICK: begin
               if (omode_ff != dsp_pkg::OUT_MUTE) begin
                  if (next_pos >= CW'(bsize_ff)) begin
                     pos_in = '0;
                     if (!ring_ff) omode_in = dsp_pkg::OUT_MUTE;
                  end else begin
                     pos_in = IW'(next_pos);
                  end
               end
            end
            dsp_pkg::KIND_SET: begin
               unique case (f_omode)
                  dsp_pkg::OUT_MUTE:   omode_in = dsp_pkg::OUT_MUTE;
                  dsp_pkg::OUT_MONO:   omode_in = dsp_pkg::OUT_MONO;
                  dsp_pkg::OUT_STEREO: omode_in = dsp_pkg::OUT_STEREO;
                  default:             omode_in = omode_ff;
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // Store: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (accept && (req_tuser == dsp_pkg::KIND_WRITE)) begin
         sample_store_ff[wr_addr] <= f_value;
      end
      if (tick) begin
         rd_l_ff <= sample_store_ff[pos_ff];
         rd_r_ff <= sample_store_ff[pos_p1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff <= dsp_pkg::BUFFER_SIZE_RST;
         ring_ff  <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            dsp_pkg::CSR_BUFFER_SIZE: bsize_ff <= csr_wdata;
            dsp_pkg::CSR_RING_MODE:   ring_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         omode_ff <= dsp_pkg::OUT_MUTE;
      end else begin
         pos_ff   <= pos_in;
         omode_ff <= omode_in;
      end
   end

   // Read stage: hold tick flags while the output register is full and rsp is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (tick) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         s1_mute_ff <= (omode_ff == dsp_pkg::OUT_MUTE);
         s1_mono_ff <= (omode_ff == dsp_pkg::OUT_MONO);
      end
   end

   assign left_w  = s1_mute_ff ? dsp_pkg::MUTE_WORD : rd_l_ff;
   assign right_w = s1_mute_ff ? dsp_pkg::MUTE_WORD : (s1_mono_ff ? rd_l_ff : rd_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_data_ff <= {right_w, left_w};
         out_pd_ff   <= s1_mute_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_pd_ff;

endmodule

>>> hdl/dsp_checker.sv
// Port-level checks for dac_sample_playback_core, bound into every instance of it.
// Depends on dsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic [31:0] mute_pair;
   logic [32:0] rsp_word;
   logic        rsp_stall;

   assign mute_pair = {dsp_pkg::MUTE_WORD, dsp_pkg::MUTE_WORD};
   assign rsp_word  = {rsp_tuser, rsp_tdata};
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `DSP_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word), "rsp word moved")
   `DSP_ASSERT_NOW(a_mute_word, rsp_tvalid && rsp_tuser, rsp_tdata == mute_pair, "bad mute word")
   `DSP_ASSERT_ALWAYS(a_reset_idle, reset, !rsp_tvalid, "rsp valid after reset")
   `DSP_ASSERT_NOW(a_ready_empty, !rsp_tvalid, req_tready, "req stalled with empty output")

endmodule

bind dac_sample_playback_core dsp_checker u_dsp_checker (.*);
